>>> sv/ils_pkg.sv
`default_nettype none

package ils_pkg;

  localparam int POS_W            = 5;
  localparam int DATA_W           = 32;
  localparam int CNT_W            = 5;
  localparam int EXT_W            = 64;
  localparam int CAPACITY_DEF     = 16;
  localparam int VALUE_WIDTH_DEF  = 32;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_SET    = 2'd2,
    OP_GET    = 2'd3
  } ils_op_t;

  // command broadcast from the controller to every cell
  typedef struct packed {
    logic             ins;
    logic             del;
    logic             set;
    logic             load;
    logic             shift;
    logic [POS_W-1:0] pos;
  } ils_cmd_t;

  typedef struct packed {
    logic              ok;
    logic [DATA_W-1:0] read_value;
    logic [CNT_W-1:0]  entry_count;
  } ils_res_t;

endpackage

`default_nettype wire

>>> sv/ils_req_if.sv
`default_nettype none

interface ils_req_if;
  import ils_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [1:0]               opcode;
  logic [POS_W-1:0]         position;
  logic signed [DATA_W-1:0] item_value;

  modport source (output valid, output opcode, output position, output item_value,
                  input ready);
  modport sink   (input valid, input opcode, input position, input item_value,
                  output ready);
endinterface

`default_nettype wire

>>> sv/ils_rsp_if.sv
`default_nettype none

interface ils_rsp_if;
  import ils_pkg::*;

  logic                     valid;
  logic                     ready;
  logic                     ok;
  logic signed [DATA_W-1:0] read_value;
  logic [CNT_W-1:0]         entry_count;

  modport source (output valid, output ok, output read_value, output entry_count,
                  input ready);
  modport sink   (input valid, input ok, input read_value, input entry_count,
                  output ready);
endinterface

`default_nettype wire

>>> sv/ils_cell.sv
`default_nettype none

module ils_cell #(
  parameter int IDX         = 0,
  parameter int VALUE_WIDTH = ils_pkg::VALUE_WIDTH_DEF
) (
  input  logic                   clk,
  input  ils_pkg::ils_cmd_t      cmd,
  input  logic [VALUE_WIDTH-1:0] wr_value,
  input  logic [VALUE_WIDTH-1:0] left_entry,
  input  logic [VALUE_WIDTH-1:0] right_entry,
  input  logic [VALUE_WIDTH-1:0] right_rd,
  output logic [VALUE_WIDTH-1:0] entry_out,
  output logic [VALUE_WIDTH-1:0] rd_out
);
  import ils_pkg::*;

  logic [VALUE_WIDTH-1:0] entry_r, entry_nxt;
  logic [VALUE_WIDTH-1:0] rd_r, rd_nxt;
  logic                   at_pos;
  logic                   above_pos;

  assign at_pos    = (32'(cmd.pos) == 32'(IDX));
  assign above_pos = (32'(IDX) > 32'(cmd.pos));

  always_comb begin
    entry_nxt = entry_r;
    priority if (cmd.ins && above_pos) begin
      entry_nxt = left_entry;
    end else if ((cmd.ins || cmd.set) && at_pos) begin
      entry_nxt = wr_value;
    end else if (cmd.del && (above_pos || at_pos)) begin
      entry_nxt = right_entry;
    end else begin
      entry_nxt = entry_r;
    end
  end

  // read chain: snapshot on load, then walk toward cell zero
  always_comb begin
    rd_nxt = rd_r;
    priority if (cmd.load) begin
      rd_nxt = entry_r;
    end else if (cmd.shift) begin
      rd_nxt = right_rd;
    end else begin
      rd_nxt = rd_r;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
    rd_r    <= rd_nxt;
  end

  assign entry_out = entry_r;
  assign rd_out    = rd_r;

endmodule

`default_nettype wire

>>> sv/ils_ctrl.sv
`default_nettype none

module ils_ctrl #(
  parameter int CAPACITY    = ils_pkg::CAPACITY_DEF,
  parameter int VALUE_WIDTH = ils_pkg::VALUE_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  ils_req_if.sink                in_req,
  ils_rsp_if.source              out_rsp,
  output ils_pkg::ils_cmd_t      cmd,
  output logic [VALUE_WIDTH-1:0] wr_value,
  input  logic [VALUE_WIDTH-1:0] rd_head
);
  import ils_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);

  typedef enum logic {
    ST_IDLE,
    ST_READ
  } state_t;

  state_t           state_r;
  logic [CW-1:0]    count_r, count_nxt;
  logic [POS_W-1:0] rem_r;
  logic             out_valid_r, skid_valid_r;
  ils_res_t         out_r, skid_r, res;

  ils_op_t                       op;
  logic                          acc;
  logic                          ok_w;
  logic                          in_list;
  logic                          ins_ok;
  logic                          produce;
  logic                          take;
  logic [EXT_W-1:0]              ext_in;
  logic signed [VALUE_WIDTH-1:0] rd_s;
  logic [EXT_W-1:0]              ext_rd;

  assign op             = ils_op_t'(in_req.opcode);
  assign in_req.ready   = (state_r == ST_IDLE) && !skid_valid_r;
  assign acc            = in_req.valid && in_req.ready;
  assign take           = out_valid_r && out_rsp.ready;

  assign in_list = (32'(in_req.position) < 32'(count_r));
  assign ins_ok  = (32'(in_req.position) <= 32'(count_r)) && (count_r < CW'(CAPACITY));

  assign ext_in   = EXT_W'(in_req.item_value);
  assign wr_value = ext_in[VALUE_WIDTH-1:0];
  assign rd_s     = rd_head;
  assign ext_rd   = EXT_W'(rd_s);

  always_comb begin
    ok_w      = 1'b0;
    count_nxt = count_r;
    unique case (op)
      OP_INSERT: begin
        ok_w = ins_ok;
        if (ins_ok) begin
          count_nxt = count_r + CW'(1);
        end
      end
      OP_DELETE: begin
        ok_w = in_list;
        if (in_list) begin
          count_nxt = count_r - CW'(1);
        end
      end
      OP_SET:  ok_w = in_list;
      OP_GET:  ok_w = in_list;
      default: ok_w = 1'b0;
    endcase
  end

  always_comb begin
    cmd.ins   = acc && (op == OP_INSERT) && ok_w;
    cmd.del   = acc && (op == OP_DELETE) && ok_w;
    cmd.set   = acc && (op == OP_SET) && ok_w;
    cmd.load  = acc && (op == OP_GET) && ok_w;
    cmd.shift = (state_r == ST_READ) && (rem_r != '0);
    cmd.pos   = in_req.position;
  end

  always_comb begin
    produce = 1'b0;
    res     = '0;
    priority if (acc && !((op == OP_GET) && ok_w)) begin
      produce         = 1'b1;
      res.ok          = ok_w;
      res.entry_count = CNT_W'(count_nxt);
    end else if ((state_r == ST_READ) && (rem_r == '0)) begin
      produce         = 1'b1;
      res.ok          = 1'b1;
      res.read_value  = ext_rd[DATA_W-1:0];
      res.entry_count = CNT_W'(count_r);
    end else begin
      produce = 1'b0;
      res     = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      count_r      <= '0;
      rem_r        <= '0;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (acc) begin
        count_r <= count_nxt;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (cmd.load) begin
            state_r <= ST_READ;
            rem_r   <= in_req.position;
          end
        end
        ST_READ: begin
          if (rem_r == '0) begin
            state_r <= ST_IDLE;
          end else begin
            rem_r <= rem_r - POS_W'(1);
          end
        end
        default: state_r <= ST_IDLE;
      endcase
      priority if (produce) begin
        if (!out_valid_r || take) begin
          out_valid_r <= 1'b1;
        end else begin
          skid_valid_r <= 1'b1;
        end
      end else if (take) begin
        if (skid_valid_r) begin
          skid_valid_r <= 1'b0;
        end else begin
          out_valid_r <= 1'b0;
        end
      end else begin
        out_valid_r <= out_valid_r;
      end
    end
  end

  // result payload, no reset
  always_ff @(posedge clk) begin
    priority if (produce) begin
      if (!out_valid_r || take) begin
        out_r <= res;
      end else begin
        skid_r <= res;
      end
    end else if (take && skid_valid_r) begin
      out_r <= skid_r;
    end else begin
      out_r <= out_r;
    end
  end

  assign out_rsp.valid       = out_valid_r;
  assign out_rsp.ok          = out_r.ok;
  assign out_rsp.read_value  = out_r.read_value;
  assign out_rsp.entry_count = out_r.entry_count;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(count_r) <= 32'(CAPACITY))
    else $error("entry count above capacity");

  a_skid_order: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid slot holds a result while output slot is empty");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    produce |-> !skid_valid_r)
    else $error("result produced with both result slots full");

  a_quick_result: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && (op != OP_GET)) |=> out_valid_r)
    else $error("no result after a non-read transaction");

  a_read_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_READ) |-> !acc)
    else $error("transaction accepted during a read walk");

endmodule

`default_nettype wire

>>> sv/indexed_list_store.sv
// Indexed list store: an ordered list of up to CAPACITY signed values, addressed by
// position, held in a row of cells, one entry per cell. Insert, delete and set finish
// in the cycle of the transaction: every cell compares its index with the position and
// takes its own, its left or its right neighbor's value at once, and the result
// (ok, read_value, entry_count) is registered into the output slot, or into the skid
// slot while the output slot still waits. A get snapshots the row into a read chain and
// walks it one cell per cycle toward cell zero, then registers its result; no new request
// is taken during that walk. Two result slots let a request be accepted while an earlier
// result still waits. Failed requests only clear ok and leave the list unchanged.
`default_nettype none

module indexed_list_store #(
  parameter int CAPACITY    = ils_pkg::CAPACITY_DEF,
  parameter int VALUE_WIDTH = ils_pkg::VALUE_WIDTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  ils_req_if.sink   in_req,
  ils_rsp_if.source out_rsp
);
  import ils_pkg::*;

  ils_cmd_t               cmd;
  logic [VALUE_WIDTH-1:0] wr_value;
  logic [VALUE_WIDTH-1:0] entry_w    [CAPACITY];
  logic [VALUE_WIDTH-1:0] rd_w       [CAPACITY];
  logic [VALUE_WIDTH-1:0] left_w     [CAPACITY];
  logic [VALUE_WIDTH-1:0] right_w    [CAPACITY];
  logic [VALUE_WIDTH-1:0] right_rd_w [CAPACITY];

  ils_ctrl #(
    .CAPACITY    (CAPACITY),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_req   (in_req),
    .out_rsp  (out_rsp),
    .cmd      (cmd),
    .wr_value (wr_value),
    .rd_head  (rd_w[0])
  );

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    if (i == 0) begin : g_first
      assign left_w[i] = '0;
    end else begin : g_left
      assign left_w[i] = entry_w[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_w[i]    = '0;
      assign right_rd_w[i] = '0;
    end else begin : g_right
      assign right_w[i]    = entry_w[i+1];
      assign right_rd_w[i] = rd_w[i+1];
    end

    ils_cell #(
      .IDX         (i),
      .VALUE_WIDTH (VALUE_WIDTH)
    ) u_cell (
      .clk         (clk),
      .cmd         (cmd),
      .wr_value    (wr_value),
      .left_entry  (left_w[i]),
      .right_entry (right_w[i]),
      .right_rd    (right_rd_w[i]),
      .entry_out   (entry_w[i]),
      .rd_out      (rd_w[i])
    );
  end

endmodule

`default_nettype wire
